/* rtl/epcg_pkg.sv */
//------------------------------------------------------------------------------
// epcg_pkg
// Types, constants and tables shared by the entropy pool cookie generator.
//------------------------------------------------------------------------------
package epcg_pkg;

  localparam int WORD_W = 32;

  typedef struct packed {
    logic        req_type;
    logic [31:0] entropy_word;
    logic        long_output;
  } cmd_t;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;

  function automatic logic [31:0] twist(input logic [2:0] i);
    logic [31:0] r;
    case (i)
      3'd0: r = 32'h00000000;
      3'd1: r = 32'h3b6e20c8;
      3'd2: r = 32'h76dc4190;
      3'd3: r = 32'h4db26158;
      3'd4: r = 32'hedb88320;
      3'd5: r = 32'hd6d6a3e8;
      3'd6: r = 32'h9b64c2b0;
      default: r = 32'ha00ae278;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] md5k(input logic [5:0] i);
    logic [31:0] r;
    case (i)
      6'd0: r = 32'hd76aa478; 6'd1: r = 32'he8c7b756; 6'd2: r = 32'h242070db;
      6'd3: r = 32'hc1bdceee; 6'd4: r = 32'hf57c0faf; 6'd5: r = 32'h4787c62a;
      6'd6: r = 32'ha8304613; 6'd7: r = 32'hfd469501; 6'd8: r = 32'h698098d8;
      6'd9: r = 32'h8b44f7af; 6'd10: r = 32'hffff5bb1; 6'd11: r = 32'h895cd7be;
      6'd12: r = 32'h6b901122; 6'd13: r = 32'hfd987193; 6'd14: r = 32'ha679438e;
      6'd15: r = 32'h49b40821; 6'd16: r = 32'hf61e2562; 6'd17: r = 32'hc040b340;
      6'd18: r = 32'h265e5a51; 6'd19: r = 32'he9b6c7aa; 6'd20: r = 32'hd62f105d;
      6'd21: r = 32'h02441453; 6'd22: r = 32'hd8a1e681; 6'd23: r = 32'he7d3fbc8;
      6'd24: r = 32'h21e1cde6; 6'd25: r = 32'hc33707d6; 6'd26: r = 32'hf4d50d87;
      6'd27: r = 32'h455a14ed; 6'd28: r = 32'ha9e3e905; 6'd29: r = 32'hfcefa3f8;
      6'd30: r = 32'h676f02d9; 6'd31: r = 32'h8d2a4c8a; 6'd32: r = 32'hfffa3942;
      6'd33: r = 32'h8771f681; 6'd34: r = 32'h6d9d6122; 6'd35: r = 32'hfde5380c;
      6'd36: r = 32'ha4beea44; 6'd37: r = 32'h4bdecfa9; 6'd38: r = 32'hf6bb4b60;
      6'd39: r = 32'hbebfbc70; 6'd40: r = 32'h289b7ec6; 6'd41: r = 32'heaa127fa;
      6'd42: r = 32'hd4ef3085; 6'd43: r = 32'h04881d05; 6'd44: r = 32'hd9d4d039;
      6'd45: r = 32'he6db99e5; 6'd46: r = 32'h1fa27cf8; 6'd47: r = 32'hc4ac5665;
      6'd48: r = 32'hf4292244; 6'd49: r = 32'h432aff97; 6'd50: r = 32'hab9423a7;
      6'd51: r = 32'hfc93a039; 6'd52: r = 32'h655b59c3; 6'd53: r = 32'h8f0ccc92;
      6'd54: r = 32'hffeff47d; 6'd55: r = 32'h85845dd1; 6'd56: r = 32'h6fa87e4f;
      6'd57: r = 32'hfe2ce6e0; 6'd58: r = 32'ha3014314; 6'd59: r = 32'h4e0811a1;
      6'd60: r = 32'hf7537e82; 6'd61: r = 32'hbd3af235; 6'd62: r = 32'h2ad7d2bb;
      default: r = 32'heb86d391;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] md5s(input logic [3:0] i);
    logic [4:0] r;
    case (i)
      4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
      4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
      4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
      4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] d;
    d = {x, x} << s;
    return d[63:32];
  endfunction

endpackage

/* rtl/entropy_pool_cookie_generator.sv */
//------------------------------------------------------------------------------
// entropy_pool_cookie_generator
// Entropy pool with TGFSR mixing and MD5 extraction of cookie words.
//------------------------------------------------------------------------------
// channel | dir | tdata                           | tuser    | tlast
// s_axis  | in  | [31:0] entropy_word, [32] long  | req_type | -
// m_axis  | out | [31:0] out_word                 | -        | last
// Add beat: issue, six pool reads through one registered port, then write.
// Extract beat: issue, 128 MD5 steps (a read and a step each, two blocks of 64),
// a finalize and a pool mix after each block, then the result beats.
// After reset a clearing pass zeroes the pool; commands queue but wait.
// Two-entry command queue lets input beats land while results stall.
//------------------------------------------------------------------------------
module entropy_pool_cookie_generator import epcg_pkg::*; #(
  parameter int POOL_WORDS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // [31:0] entropy_word, [32] long_output
  input  logic        s_axis_tuser,  // [0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [31:0] out_word
  output logic        m_axis_tlast
);

  cmd_t        in_cmd;
  cmd_t        q_cmd;
  logic        q_valid, q_ready;
  logic        o_valid, o_ready, o_last;
  logic [31:0] o_word;

  assign in_cmd.req_type     = s_axis_tuser;
  assign in_cmd.entropy_word = s_axis_tdata[31:0];
  assign in_cmd.long_output  = s_axis_tdata[32];

  epcg_front u_front (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd,
    .q_valid, .q_ready, .q_cmd
  );

  epcg_back #(.POOL_WORDS(POOL_WORDS)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_cmd, .o_valid, .o_ready, .o_word, .o_last
  );

  epcg_out u_out (
    .clk, .rst, .i_valid(o_valid), .i_ready(o_ready), .i_word(o_word), .i_last(o_last),
    .tvalid(m_axis_tvalid), .tready(m_axis_tready), .tdata(m_axis_tdata),
    .tlast(m_axis_tlast)
  );

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");
  a_queue_stall: assert property (@(posedge clk) disable iff (rst)
    q_valid && !q_ready && !s_axis_tready |=> !s_axis_tready || q_ready)
    else $error("queue freed without pop");
  a_emit_pop: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> !q_ready)
    else $error("command popped while results pending");
`endif

endmodule

/* rtl/epcg_front.sv */
//------------------------------------------------------------------------------
// epcg_front
// Input stage and two-entry command queue toward the pool engine.
//------------------------------------------------------------------------------
module epcg_front import epcg_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  cmd_t  in_cmd,
  output logic  q_valid,
  input  logic  q_ready,
  output cmd_t  q_cmd
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_cmd    = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_cmd;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* rtl/epcg_back.sv */
//------------------------------------------------------------------------------
// epcg_back
// Pool engine: TGFSR mixing over a pool memory and a shared MD5 round unit.
//------------------------------------------------------------------------------
module epcg_back import epcg_pkg::*; #(
  parameter int POOL_WORDS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_ready,
  input  cmd_t        q_cmd,
  output logic        o_valid,
  input  logic        o_ready,
  output logic [31:0] o_word,
  output logic        o_last
);

  localparam int AW = $clog2(POOL_WORDS);

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_MIX_RD, S_MIX_ACC, S_MIX_WR, S_MD5_RD, S_MD5_STEP,
    S_MD5_FIN, S_EMIT
  } state_t;

  state_t      state;
  logic [31:0] pool [POOL_WORDS];
  logic [31:0] rdata;
  logic [AW-1:0] raddr;
  logic [AW-1:0] clr_addr;
  logic [4:0]  rot;
  logic [AW-1:0] ptr;
  logic [31:0] acc;
  logic [2:0]  tap;
  logic        rd_pend;
  logic        long_q;
  logic        phase;
  logic [6:0]  step;
  logic [31:0] a, b, c, d;
  logic [31:0] h0, h1, h2, h3;
  logic [1:0]  emit_idx;
  logic [AW-1:0] p_new;
  logic [AW-1:0] tap_off;
  logic [31:0] f;
  logic [3:0]  g;
  logic [5:0]  si;
  logic [31:0] t;
  logic [31:0] wmix;

  assign si    = step[5:0];
  assign p_new = ptr - AW'(1);

  always_comb begin
    case (tap)
      3'd0: tap_off = AW'(26);
      3'd1: tap_off = AW'(20);
      3'd2: tap_off = AW'(14);
      3'd3: tap_off = AW'(7);
      3'd4: tap_off = AW'(1);
      default: tap_off = AW'(0);
    endcase
  end

  always_comb begin
    case (si[5:4])
      2'd0: begin f = d ^ (b & (c ^ d)); g = si[3:0]; end
      2'd1: begin f = c ^ (d & (b ^ c)); g = 4'(5 * si + 1); end
      2'd2: begin f = b ^ c ^ d; g = 4'(3 * si + 5); end
      default: begin f = c ^ (b | ~d); g = 4'(7 * si); end
    endcase
  end

  assign t    = a + f + md5k(si) + rdata;
  assign wmix = acc ^ rdata;

  always_ff @(posedge clk) begin
    if (state == S_CLR) begin
      pool[clr_addr] <= '0;
    end else if (state == S_MIX_WR) begin
      pool[ptr] <= (wmix >> 3) ^ twist(wmix[2:0]);
    end
    rdata <= pool[raddr];
  end

  always_comb begin
    case (state)
      S_MIX_RD, S_MIX_ACC: raddr = ptr + tap_off;
      default: raddr = {phase, g};
    endcase
  end

  assign q_ready = (state == S_IDLE);
  assign o_valid = (state == S_EMIT);
  always_comb begin
    case (emit_idx)
      2'd0: o_word = h0;
      2'd1: o_word = h1;
      2'd2: o_word = h2;
      default: o_word = h3;
    endcase
  end
  assign o_last = long_q ? (emit_idx == 2'd3) : (emit_idx == 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_addr <= '0;
      rot      <= '0;
      ptr      <= '0;
      emit_idx <= '0;
      phase    <= 1'b0;
      rd_pend  <= 1'b0;
    end else begin
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(POOL_WORDS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            long_q <= q_cmd.long_output;
            if (q_cmd.req_type) begin
              h0 <= IV0; h1 <= IV1; h2 <= IV2; h3 <= IV3;
              a <= IV0; b <= IV1; c <= IV2; d <= IV3;
              phase <= 1'b0;
              step <= '0;
              rd_pend <= 1'b1;
              state <= S_MD5_RD;
            end else begin
              acc   <= rotl(q_cmd.entropy_word, rot);
              rd_pend <= 1'b0;
              state <= S_MIX_RD;
            end
            ptr <= p_new;
            tap <= '0;
            if (!q_cmd.req_type) rot <= rot + ((p_new == '0) ? 5'd14 : 5'd7);
          end
        end
        S_MIX_RD: begin
          tap <= tap + 3'd1;
          state <= S_MIX_ACC;
        end
        S_MIX_ACC: begin
          acc <= wmix;
          if (tap == 3'd5) begin
            state <= S_MIX_WR;
          end else begin
            tap <= tap + 3'd1;
          end
        end
        S_MIX_WR: begin
          if (rd_pend) begin
            if (!phase) begin
              phase <= 1'b1;
              a <= h0; b <= h1; c <= h2; d <= h3;
              step <= '0;
              state <= S_MD5_RD;
            end else begin
              rd_pend <= 1'b0;
              emit_idx <= '0;
              state <= S_EMIT;
            end
          end else begin
            state <= S_IDLE;
          end
        end
        S_MD5_RD: state <= S_MD5_STEP;
        S_MD5_STEP: begin
          a <= d; d <= c; c <= b;
          b <= b + rotl(t, md5s({si[5:4], si[1:0]}));
          step <= step + 7'd1;
          state <= (si == 6'd63) ? S_MD5_FIN : S_MD5_RD;
        end
        S_MD5_FIN: begin
          h0 <= h0 + a; h1 <= h1 + b; h2 <= h2 + c; h3 <= h3 + d;
          acc <= rotl(phase ? (h2 + c) : (h0 + a), rot);
          if (phase) ptr <= ptr - AW'(1);
          rot <= rot + ((ptr - AW'(phase)) == '0 ? 5'd14 : 5'd7);
          tap <= '0;
          state <= S_MIX_RD;
        end
        S_EMIT: begin
          if (o_ready) begin
            emit_idx <= emit_idx + 2'd1;
            if (o_last) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/epcg_out.sv */
//------------------------------------------------------------------------------
// epcg_out
// Output pipeline register for result beats.
//------------------------------------------------------------------------------
module epcg_out (
  input  logic        clk,
  input  logic        rst,
  input  logic        i_valid,
  output logic        i_ready,
  input  logic [31:0] i_word,
  input  logic        i_last,
  output logic        tvalid,
  input  logic        tready,
  output logic [31:0] tdata,
  output logic        tlast
);

  assign i_ready = !tvalid || tready;

  always_ff @(posedge clk) begin
    if (i_valid && i_ready) begin
      tdata <= i_word;
      tlast <= i_last;
    end
    if (rst) begin
      tvalid <= 1'b0;
    end else if (i_ready) begin
      tvalid <= i_valid;
    end
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb_top
// Drives add and extract beats into the cookie generator, keeps its own pool
// model, and checks every cookie word and tlast against the predicted chain.
//------------------------------------------------------------------------------
module tb_top;
  import epcg_pkg::*;

  localparam int TIMEOUT = 2000000;
  localparam logic REQ_ADD = 1'b0;
  localparam logic REQ_EXTRACT = 1'b1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;

  logic [31:0] pool_q [32];
  logic [4:0]  rot_q;
  logic [4:0]  ptr_q;
  logic [32:0] cookie_q [$];
  int          errors = 0;
  int          cycles = 0;
  bit          calm = 1'b0;

  entropy_pool_cookie_generator i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] rol32(logic [31:0] x, int s);
    s = s & 31;
    return (s == 0) ? x : ((x << s) | (x >> (32 - s)));
  endfunction

  function automatic logic [31:0] twist_of(logic [2:0] i);
    logic [31:0] t [8];
    t = '{32'h00000000, 32'h3b6e20c8, 32'h76dc4190, 32'h4db26158,
          32'hedb88320, 32'hd6d6a3e8, 32'h9b64c2b0, 32'ha00ae278};
    return t[i];
  endfunction

  task automatic stir_pool(logic [31:0] word);
    logic [31:0] w;
    logic [4:0]  p;
    w = rol32(word, rot_q);
    p = ptr_q - 5'd1;
    ptr_q = p;
    rot_q = rot_q + ((p != 0) ? 5'd7 : 5'd14);
    w = w ^ pool_q[5'(p + 26)] ^ pool_q[5'(p + 20)] ^ pool_q[5'(p + 14)]
          ^ pool_q[5'(p + 7)] ^ pool_q[5'(p + 1)] ^ pool_q[p];
    pool_q[p] = (w >> 3) ^ twist_of(w[2:0]);
  endtask

  task automatic md5_block(ref logic [31:0] h [4], input int base);
    logic [31:0] k [64];
    int          sh [16];
    logic [31:0] a, b, c, d, f, t;
    int          g, r;
    k = '{32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
          32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
          32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
          32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
          32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
          32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
          32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
          32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
          32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
          32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
          32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
          32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
          32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
          32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
          32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
          32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    sh = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    a = h[0]; b = h[1]; c = h[2]; d = h[3];
    for (int i = 0; i < 64; i++) begin
      r = i / 16;
      case (r)
        0: begin f = d ^ (b & (c ^ d)); g = i; end
        1: begin f = c ^ (d & (b ^ c)); g = (5 * i + 1) % 16; end
        2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
        default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
      endcase
      t = a + f + k[i] + pool_q[base + g];
      a = d; d = c; c = b;
      b = b + rol32(t, sh[r * 4 + i % 4]);
    end
    h[0] += a; h[1] += b; h[2] += c; h[3] += d;
  endtask

  task automatic predict_cookie(logic req, logic [31:0] word, logic long_out);
    logic [31:0] h [4];
    int          n;
    if (req == REQ_ADD) begin
      stir_pool(word);
    end else begin
      h = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};
      md5_block(h, 0);
      stir_pool(h[0]);
      md5_block(h, 16);
      stir_pool(h[2]);
      n = long_out ? 4 : 2;
      for (int i = 0; i < n; i++) cookie_q.push_back({i == n - 1, h[i]});
    end
  endtask

  task automatic send_beat(logic req, logic [31:0] word, logic long_out);
    if (!calm && $urandom_range(99) < 17) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= req;
    s_axis_tdata <= {7'd0, long_out, word};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_cookie(req, word, long_out);
    @(negedge clk);
  endtask

  always @(negedge clk) m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 17);

  always @(posedge clk) begin
    logic [32:0] exp_v;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (cookie_q.size() == 0) begin
        $display("%0t: unexpected word %h last %b", $time, m_axis_tdata, m_axis_tlast);
        errors++;
      end else begin
        exp_v = cookie_q.pop_front();
        if (m_axis_tdata !== exp_v[31:0] || m_axis_tlast !== exp_v[32]) begin
          $display("%0t: expected %h last %b, got %h last %b", $time,
                   exp_v[31:0], exp_v[32], m_axis_tdata, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > TIMEOUT) begin
      $display("[entropy_pool_cookie_generator] ERROR");
      $finish;
    end
  end

  task automatic test_directed();
    send_beat(REQ_EXTRACT, 32'hffffffff, 1'b0);
    send_beat(REQ_EXTRACT, 32'h0, 1'b1);
    send_beat(REQ_ADD, 32'h0, 1'b1);
    send_beat(REQ_ADD, 32'hffffffff, 1'b0);
    send_beat(REQ_ADD, 32'h80000001, 1'b1);
    send_beat(REQ_ADD, 32'h00000001, 1'b0);
    send_beat(REQ_EXTRACT, 32'hdeadbeef, 1'b1);
    for (int i = 0; i < 34; i++) send_beat(REQ_ADD, 32'h1 << (i % 32), i[0]);
    send_beat(REQ_EXTRACT, 32'h12345678, 1'b0);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      calm = (i >= count / 2) && (i < count / 2 + 60);
      send_beat(($urandom_range(99) < 15) ? REQ_EXTRACT : REQ_ADD, $urandom, $urandom_range(1));
    end
    calm = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < 32; i++) pool_q[i] = '0;
    rot_q = '0;
    ptr_q = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(420);
    s_axis_tvalid <= 1'b0;
    while (cookie_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0) begin
      $display("[entropy_pool_cookie_generator] OK");
    end else begin
      $display("[entropy_pool_cookie_generator] ERROR");
    end
    $finish;
  end
endmodule

/* sim.f */
rtl/epcg_pkg.sv
rtl/epcg_front.sv
rtl/epcg_back.sv
rtl/epcg_out.sv
rtl/entropy_pool_cookie_generator.sv
sim/tb_top.sv
